### hw/rtl/tnri_pkg.sv
// shared types, widths and constants of the two-nearest reference interpolator
// used by every module of the block, depends on nothing
package tnri_pkg;

	localparam int CHAN_W   = 12;
	localparam int NUM_CHAN = 3;
	localparam int PH_W     = 10;
	localparam int REF_W    = 46;
	localparam int SQ_W     = 2 * CHAN_W;
	localparam int DIST_W   = 26;
	localparam int SUM_W    = DIST_W + 1;
	localparam int PHOUT_W  = 17;
	localparam int NUM_W    = PHOUT_W + DIST_W;
	localparam int IDX_W    = 3;
	localparam int MAX_REFS = 8;

	localparam logic [PHOUT_W-1:0] PH_SCALE  = 17'd100;
	localparam logic [PHOUT_W-1:0] PH_OUT_MAX = 17'd102300;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [REF_W-1:0]   ref_t;
	typedef logic [PH_W-1:0]    ph_t;
	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [IDX_W-1:0]   idx_t;

	// reference colours after reset: 6.80, 7.20, 7.50, 7.80, 8.20, spare entries zero
	localparam ref_t REF_RESET [MAX_REFS] = '{
		46'd46748382907720,
		46'd49506559676220,
		46'd51554712619620,
		46'd53615456832470,
		46'd56367756905100,
		46'd0,
		46'd0,
		46'd0
	};

	// fields that ride beside the quotient through the divider
	typedef struct packed {
		logic [PHOUT_W-1:0] base;
		logic               neg;
		logic               zero;
		idx_t               near_idx;
		idx_t               second_idx;
		dist_t              near_dist;
	} side_t;

	function automatic chan_t chan_of(input ref_t r, input int c);
		return r[c*CHAN_W +: CHAN_W];
	endfunction

	function automatic ph_t ph_of(input ref_t r);
		return r[REF_W-1 -: PH_W];
	endfunction

	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

### hw/rtl/tnri_distance.sv
// squared colour distance to every reference, three pipeline stages
// depends on tnri_pkg
module tnri_distance #(
	parameter int NUM_REFERENCES = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tnri_pkg::chan_t red,
	input  tnri_pkg::chan_t green,
	input  tnri_pkg::chan_t blue,
	input  tnri_pkg::ref_t  refs [NUM_REFERENCES],
	output logic            out_valid,
	input  logic            out_ready,
	output tnri_pkg::dist_t dist_sq [NUM_REFERENCES]
);
	import tnri_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	chan_t             diff_s1 [NUM_REFERENCES][NUM_CHAN];
	logic [SQ_W-1:0]   sq_s2   [NUM_REFERENCES][NUM_CHAN];
	dist_t             dist_s3 [NUM_REFERENCES];
	chan_t             sample  [NUM_CHAN];

	assign sample[0] = red;
	assign sample[1] = green;
	assign sample[2] = blue;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_REFERENCES; i++) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				if (en1) begin
					diff_s1[i][c] <= abs_diff(sample[c], chan_of(refs[i], c));
				end
				if (en2) begin
					sq_s2[i][c] <= SQ_W'(diff_s1[i][c]) * SQ_W'(diff_s1[i][c]);
				end
			end
			if (en3) begin
				dist_s3[i] <= DIST_W'(sq_s2[i][0]) + DIST_W'(sq_s2[i][1])
					+ DIST_W'(sq_s2[i][2]);
			end
		end
	end

	assign out_valid = v_s3;
	assign dist_sq   = dist_s3;

endmodule

### hw/rtl/tnri_select.sv
// nearest and second-nearest search, blend setup and the weight product
// depends on tnri_pkg
module tnri_select #(
	parameter int NUM_REFERENCES = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tnri_pkg::dist_t                  dist_sq [NUM_REFERENCES],
	input  tnri_pkg::ref_t                   refs [NUM_REFERENCES],
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tnri_pkg::NUM_W-1:0]       num,
	output logic [tnri_pkg::SUM_W-1:0]       den,
	output tnri_pkg::side_t                  side
);
	import tnri_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic en4, en5, en6;

	dist_t near_dist_s4, second_dist_s4;
	ph_t   near_ph_s4, second_ph_s4;
	idx_t  near_idx_s4, second_idx_s4;

	logic [PHOUT_W-1:0] mag_s5;
	logic [SUM_W-1:0]   sum_s5;
	side_t              side_s5;

	logic [NUM_W-1:0]   num_s6;
	logic [SUM_W-1:0]   den_s6;
	side_t              side_s6;

	dist_t jd, kd;
	ph_t   jp, kp;
	idx_t  ji, ki;

	logic               neg_c;
	ph_t                pdiff_c;

	// ordered scan, strict less-than keeps the lower index on a tie
	always_comb begin
		if (dist_sq[1] < dist_sq[0]) begin
			jd = dist_sq[1];
			jp = ph_of(refs[1]);
			ji = IDX_W'(1);
			kd = dist_sq[0];
			kp = ph_of(refs[0]);
			ki = IDX_W'(0);
		end else begin
			jd = dist_sq[0];
			jp = ph_of(refs[0]);
			ji = IDX_W'(0);
			kd = dist_sq[1];
			kp = ph_of(refs[1]);
			ki = IDX_W'(1);
		end
		for (int i = 2; i < NUM_REFERENCES; i++) begin
			if (dist_sq[i] < jd) begin
				kd = jd;
				kp = jp;
				ki = ji;
				jd = dist_sq[i];
				jp = ph_of(refs[i]);
				ji = IDX_W'(i);
			end else if (dist_sq[i] < kd) begin
				kd = dist_sq[i];
				kp = ph_of(refs[i]);
				ki = IDX_W'(i);
			end
		end
	end

	assign neg_c   = second_ph_s4 < near_ph_s4;
	assign pdiff_c = neg_c ? (near_ph_s4 - second_ph_s4) : (second_ph_s4 - near_ph_s4);

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4) begin
				v_s4 <= in_valid;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			near_dist_s4   <= jd;
			second_dist_s4 <= kd;
			near_ph_s4     <= jp;
			second_ph_s4   <= kp;
			near_idx_s4    <= ji;
			second_idx_s4  <= ki;
		end
		if (en5) begin
			sum_s5             <= SUM_W'(near_dist_s4) + SUM_W'(second_dist_s4);
			mag_s5             <= PHOUT_W'(pdiff_c) * PH_SCALE;
			side_s5.base       <= PHOUT_W'(near_ph_s4) * PH_SCALE;
			side_s5.neg        <= neg_c;
			side_s5.zero       <= (near_dist_s4 == '0) && (second_dist_s4 == '0);
			side_s5.near_idx   <= near_idx_s4;
			side_s5.second_idx <= second_idx_s4;
			side_s5.near_dist  <= near_dist_s4;
		end
		if (en6) begin
			num_s6  <= NUM_W'(mag_s5) * NUM_W'(side_s5.near_dist);
			den_s6  <= sum_s5;
			side_s6 <= side_s5;
		end
	end

	assign out_valid = v_s6;
	assign num       = num_s6;
	assign den       = den_s6;
	assign side      = side_s6;

endmodule

### hw/rtl/tnri_divide.sv
// pipelined restoring divider, one quotient bit per stage
// depends on tnri_pkg
module tnri_divide (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tnri_pkg::NUM_W-1:0]   num,
	input  logic [tnri_pkg::SUM_W-1:0]   den,
	input  tnri_pkg::side_t              side_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tnri_pkg::PHOUT_W-1:0] quo,
	output tnri_pkg::side_t              side_out
);
	import tnri_pkg::*;

	localparam int QUO_W = PHOUT_W;

	logic               v_s   [QUO_W];
	logic               en    [QUO_W];
	logic [NUM_W-1:0]   rem_s [QUO_W];
	logic [QUO_W-1:0]   quo_s [QUO_W];
	logic [SUM_W-1:0]   den_s [QUO_W];
	side_t              side_s[QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - 1 - k;

		logic [NUM_W-1:0] rem_in;
		logic [QUO_W-1:0] quo_in;
		logic [SUM_W-1:0] den_in;
		side_t            sd_in;
		logic             v_in;
		logic             en_next;
		logic [NUM_W:0]   shifted;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign den_in = den;
			assign sd_in  = side_in;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign sd_in  = side_s[k-1];
			assign v_in   = v_s[k-1];
		end

		if (k == QUO_W - 1) begin : g_last
			assign en_next = out_ready;
		end else begin : g_mid
			assign en_next = en[k+1];
		end

		assign en[k]   = !v_s[k] || en_next;
		assign shifted = (NUM_W + 1)'(den_in) << BIT;
		assign ge      = {1'b0, rem_in} >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= ge ? (rem_in - shifted[NUM_W-1:0]) : rem_in;
				quo_s[k]  <= quo_in | (ge ? (QUO_W'(1) << BIT) : QUO_W'(0));
				den_s[k]  <= den_in;
				side_s[k] <= sd_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign side_out  = side_s[QUO_W-1];

endmodule

### hw/rtl/two_nearest_reference_interpolator_unit.sv
// top level of the two-nearest reference colour interpolator: stream ports,
// reference registers, output register; uses tnri_pkg, tnri_distance,
// tnri_select and tnri_divide
//
// channel   direction  transaction contents
// s_*       in         one colour sample: red, green, blue (12 bits each)
// m_*       out        ph_value, nearest_index, second_index, nearest_distance
// apb       in/out     reference_0 .. reference_N-1, 46 bits at byte address 8*i
//
// one sample enters and one result leaves per cycle unless m_tready stalls the output;
// stages: three distance, three select/product, 17 divider, one output register.
// the 17-stage divider, one quotient bit per stage, sets the depth.
// arst_n clears every valid bit and reloads the reference registers with their
// defaults. a stall on m_tready holds only the stages that carry data; empty stages
// keep filling, so s_tready drops only once the whole pipeline is occupied.
module two_nearest_reference_interpolator_unit #(
	parameter  int NUM_REFERENCES = 5,
	localparam int IDX_AW         = $clog2(NUM_REFERENCES),
	localparam int ADDR_W         = IDX_AW + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave side
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,   // red[11:0], green[23:12], blue[35:24], zero fill
	// master side
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,   // ph_value[16:0], nearest_index[19:17],
	                                     // second_index[22:20], nearest_distance[48:23]
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import tnri_pkg::*;

	typedef struct packed {
		dist_t              nearest_distance;
		idx_t               second_index;
		idx_t               nearest_index;
		logic [PHOUT_W-1:0] ph_value;
	} out_t;

	localparam int OUT_PAD = 56 - $bits(out_t);
	localparam logic [IDX_AW:0] NUM_C = (IDX_AW + 1)'(NUM_REFERENCES);

	// reference registers
	ref_t              ref_q [NUM_REFERENCES];
	logic [IDX_AW-1:0] cfg_idx;
	logic              cfg_hit;
	logic              cfg_wr;

	// pipeline links
	logic               dist_valid, dist_ready;
	dist_t              dist_sq [NUM_REFERENCES];
	logic               sel_valid, sel_ready;
	logic [NUM_W-1:0]   sel_num;
	logic [SUM_W-1:0]   sel_den;
	side_t              sel_side;
	logic               div_valid, div_ready;
	logic [PHOUT_W-1:0] div_quo;
	side_t              div_side;

	// output register
	logic               out_valid_q;
	out_t               out_q;
	logic               en_out;
	logic [PHOUT_W-1:0] ph_c;

	// apb: write lands in the access cycle, indexes past the table are dropped
	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:3];
	assign cfg_hit = {1'b0, cfg_idx} < NUM_C;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = cfg_hit ? 64'(ref_q[cfg_idx]) : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REFERENCES; i++) begin
				ref_q[i] <= REF_RESET[i];
			end
		end else if (cfg_wr && cfg_hit) begin
			ref_q[cfg_idx] <= pwdata[REF_W-1:0];
		end
	end

	// squared distances, stages 1 to 3
	tnri_distance #(
		.NUM_REFERENCES(NUM_REFERENCES)
	) u_distance (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.red      (s_tdata[11:0]),
		.green    (s_tdata[23:12]),
		.blue     (s_tdata[35:24]),
		.refs     (ref_q),
		.out_valid(dist_valid),
		.out_ready(dist_ready),
		.dist_sq  (dist_sq)
	);

	// nearest pair, blend terms and weight product, stages 4 to 6
	tnri_select #(
		.NUM_REFERENCES(NUM_REFERENCES)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dist_valid),
		.in_ready (dist_ready),
		.dist_sq  (dist_sq),
		.refs     (ref_q),
		.out_valid(sel_valid),
		.out_ready(sel_ready),
		.num      (sel_num),
		.den      (sel_den),
		.side     (sel_side)
	);

	// mag * d_near / (d_near + d_second), truncated
	tnri_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sel_valid),
		.in_ready (sel_ready),
		.num      (sel_num),
		.den      (sel_den),
		.side_in  (sel_side),
		.out_valid(div_valid),
		.out_ready(div_ready),
		.quo      (div_quo),
		.side_out (div_side)
	);

	// both distances zero keeps the nearest pH, otherwise move toward the second
	always_comb begin
		if (div_side.zero) begin
			ph_c = div_side.base;
		end else if (div_side.neg) begin
			ph_c = div_side.base - div_quo;
		end else begin
			ph_c = div_side.base + div_quo;
		end
	end

	assign en_out    = !out_valid_q || m_tready;
	assign div_ready = en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_q.ph_value         <= ph_c;
			out_q.nearest_index    <= div_side.near_idx;
			out_q.second_index     <= div_side.second_idx;
			out_q.nearest_distance <= div_side.near_dist;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, out_q};

`ifndef SYNTH
	// the two picks are always distinct references
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.nearest_index != out_q.second_index))
		else $error("nearest and second index coincide");

	// both indexes name a configured reference
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (({1'b0, out_q.nearest_index} < 4'(NUM_REFERENCES))
			&& ({1'b0, out_q.second_index} < 4'(NUM_REFERENCES))))
		else $error("reference index out of range");

	// back-pressure upstream only comes from a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// interpolated value stays within the pH scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.ph_value <= PH_OUT_MAX))
		else $error("ph_value above full scale");
`endif

endmodule

### verif/tnri_ph_monitor.sv
// result monitor for the two-nearest reference interpolator: tracks the reference
// registers from the apb writes, predicts each sample's result and compares it
// with the master-side stream; depends on tnri_pkg
`timescale 1ns / 1ps

module tnri_ph_monitor import tnri_pkg::*; #(
	parameter int NUM_REFERENCES = 5,
	parameter int ADDR_W         = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [39:0]       s_tdata,   // red[11:0], green[23:12], blue[35:24], zero fill
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [55:0]       m_tdata,   // ph_value[16:0], nearest_index[19:17],
	                                     // second_index[22:20], nearest_distance[48:23]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	input  logic              pready,
	output int                mismatch_count,
	output int                awaited_count
);

	typedef struct packed {
		logic [PHOUT_W-1:0] ph_value;
		idx_t               nearest_index;
		idx_t               second_index;
		dist_t              nearest_distance;
	} ph_result_t;

	ref_t       ref_bank [NUM_REFERENCES];
	ph_result_t ph_awaited [$];

	function automatic logic [SQ_W-1:0] chan_sq(input chan_t a, input chan_t c);
		logic [SQ_W-1:0] m;
		m = (a >= c) ? SQ_W'(a - c) : SQ_W'(c - a);
		return m * m;
	endfunction

	function automatic ph_result_t interpolate_ph(input chan_t r, input chan_t g, input chan_t b);
		dist_t              d [NUM_REFERENCES];
		int                 near_i;
		int                 sec_i;
		ph_t                p_near;
		ph_t                p_sec;
		logic [SUM_W-1:0]   total;
		logic [63:0]        span;
		logic [63:0]        q;
		logic [PHOUT_W-1:0] base;
		logic [PHOUT_W-1:0] ph;
		ph_result_t         res;
		for (int i = 0; i < NUM_REFERENCES; i++)
			d[i] = dist_t'(chan_sq(r, ref_bank[i][11:0])) +
			       dist_t'(chan_sq(g, ref_bank[i][23:12])) +
			       dist_t'(chan_sq(b, ref_bank[i][35:24]));
		// strict compares: the lower index keeps a tie
		near_i = 0;
		sec_i  = 1;
		if (d[1] < d[0]) begin
			near_i = 1;
			sec_i  = 0;
		end
		for (int i = 2; i < NUM_REFERENCES; i++) begin
			if (d[i] < d[near_i]) begin
				sec_i  = near_i;
				near_i = i;
			end else if (d[i] < d[sec_i]) begin
				sec_i = i;
			end
		end
		p_near = ref_bank[near_i][REF_W-1 -: PH_W];
		p_sec  = ref_bank[sec_i][REF_W-1 -: PH_W];
		base   = PHOUT_W'(p_near) * PH_SCALE;
		total  = SUM_W'(d[near_i]) + SUM_W'(d[sec_i]);
		if (total == '0) begin
			ph = base;
		end else if (p_sec >= p_near) begin
			span = 64'(p_sec - p_near) * 64'(PH_SCALE);
			q    = span * 64'(d[near_i]) / 64'(total);
			ph   = base + q[PHOUT_W-1:0];
		end else begin
			// magnitude truncates, so the result rounds toward the nearest pH
			span = 64'(p_near - p_sec) * 64'(PH_SCALE);
			q    = span * 64'(d[near_i]) / 64'(total);
			ph   = base - q[PHOUT_W-1:0];
		end
		res.ph_value         = ph;
		res.nearest_index    = idx_t'(near_i);
		res.second_index     = idx_t'(sec_i);
		res.nearest_distance = d[near_i];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ph_result_t want;
		ph_result_t got;
		int         widx;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REFERENCES; i++)
				ref_bank[i] = REF_RESET[i];
			ph_awaited.delete();
			mismatch_count = 0;
			awaited_count  = 0;
		end else begin
			if (s_tvalid && s_tready)
				ph_awaited.push_back(interpolate_ph(s_tdata[11:0], s_tdata[23:12],
				                                    s_tdata[35:24]));
			if (m_tvalid && m_tready) begin
				got.ph_value         = m_tdata[16:0];
				got.nearest_index    = m_tdata[19:17];
				got.second_index     = m_tdata[22:20];
				got.nearest_distance = m_tdata[48:23];
				if (ph_awaited.size() == 0) begin
					$error("result transaction with no sample pending: m_tdata=%h", m_tdata);
					mismatch_count++;
				end else begin
					want = ph_awaited.pop_front();
					if (got.ph_value !== want.ph_value) begin
						$error("ph_value: expected %0d, got %0d", want.ph_value, got.ph_value);
						mismatch_count++;
					end
					if (got.nearest_index !== want.nearest_index) begin
						$error("nearest_index: expected %0d, got %0d",
						       want.nearest_index, got.nearest_index);
						mismatch_count++;
					end
					if (got.second_index !== want.second_index) begin
						$error("second_index: expected %0d, got %0d",
						       want.second_index, got.second_index);
						mismatch_count++;
					end
					if (got.nearest_distance !== want.nearest_distance) begin
						$error("nearest_distance: expected %0d, got %0d",
						       want.nearest_distance, got.nearest_distance);
						mismatch_count++;
					end
				end
			end
			// writes above the last reference are dropped by the block
			widx = int'(paddr >> 3);
			if (psel && penable && pwrite && pready && widx < NUM_REFERENCES)
				ref_bank[widx] = pwdata[REF_W-1:0];
			awaited_count = ph_awaited.size();
		end
	end

endmodule

### verif/tb_two_nearest_reference_interpolator_unit.sv
// top of the interpolator testbench: clock, reset, sample and apb stimulus,
// ready back-pressure and the verdict; uses tnri_pkg, tnri_ph_monitor and the rtl
`timescale 1ns / 1ps

module tb_two_nearest_reference_interpolator_unit;
	import tnri_pkg::*;

	localparam int NUM_REFS     = 5;
	localparam int ADDR_W       = $clog2(NUM_REFS) + 3;
	localparam int DRAIN_CYCLES = 30;      // pipeline is 24 deep
	localparam int HOLD_CYCLES  = 120;     // long enough to fill every stage
	localparam int PHASE_ITEMS  = 108;
	localparam int NUM_PHASES   = 6;
	localparam int TIMEOUT_NS   = 200000;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [39:0]       s_tdata  = '0;   // red[11:0], green[23:12], blue[35:24], zero fill
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [55:0]       m_tdata;         // ph_value[16:0], nearest_index[19:17],
	                                    // second_index[22:20], nearest_distance[48:23]
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [63:0]       pwdata   = '0;
	logic [63:0]       prdata;
	logic              pready;

	int mismatch_count;
	int awaited_count;

	// traffic shaping knobs
	int tx_gap_pct    = 24;
	bit rx_steady     = 1'b0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	// copy of the programmed references, used to aim samples near them and to reuse their colours
	ref_t ref_shadow [NUM_REFS];

	always #1 clk = ~clk;

	two_nearest_reference_interpolator_unit #(
		.NUM_REFERENCES(NUM_REFS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tnri_ph_monitor #(
		.NUM_REFERENCES(NUM_REFS),
		.ADDR_W        (ADDR_W)
	) ph_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count)
	);

	// result side: random stalls, a steady mode, and a counted hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 24);
		end
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("status: fail");
		$finish;
	end

	function automatic ref_t pack_ref(input chan_t r, input chan_t g, input chan_t b,
	                                  input ph_t p);
		return {p, b, g, r};
	endfunction

	// mostly uniform, with the rails showing up often
	function automatic chan_t rand_chan();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return chan_t'($urandom_range(4095));
		endcase
	endfunction

	// a channel value jittered around c, clamped to the 12-bit range
	function automatic chan_t jitter_chan(input chan_t c);
		int v;
		v = int'(c) + int'($urandom_range(128)) - 64;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return chan_t'(v);
	endfunction

	// apb write: setup cycle then access cycle, called on a falling edge
	task automatic write_ref(input int idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_REFS)
			ref_shadow[idx] = value[REF_W-1:0];
		@(negedge clk);
	endtask

	// one sample transaction; random gaps first, returns on the falling edge after acceptance
	task automatic send_sample(input chan_t r, input chan_t g, input chan_t b);
		while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, b, g, r};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// stop offering and wait until every result is back, then let the pipeline empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (awaited_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random references, some sharing a colour with an earlier one to force ties,
	// junk above bit 45, plus a write to an index past the last reference
	task automatic load_random_refs();
		ref_t v;
		int   src;
		for (int i = 0; i < NUM_REFS; i++) begin
			if (i > 0 && $urandom_range(3) == 0) begin
				src = $urandom_range(i - 1);
				v   = pack_ref(ref_shadow[src][11:0], ref_shadow[src][23:12],
				               ref_shadow[src][35:24], ph_t'($urandom_range(1023)));
			end else begin
				v = pack_ref(rand_chan(), rand_chan(), rand_chan(),
				             ph_t'($urandom_range(1023)));
			end
			write_ref(i, {18'($urandom), v});
		end
		write_ref($urandom_range(7, NUM_REFS), {$urandom, $urandom});
	endtask

	// one random sample: exactly on a reference, close to one, or anywhere
	task automatic send_random_sample();
		int   pick;
		ref_t rf;
		pick = $urandom_range(5);
		rf   = ref_shadow[$urandom_range(NUM_REFS - 1)];
		if (pick == 0)
			send_sample(rf[11:0], rf[23:12], rf[35:24]);
		else if (pick <= 3)
			send_sample(jitter_chan(rf[11:0]), jitter_chan(rf[23:12]),
			            jitter_chan(rf[35:24]));
		else
			send_sample(rand_chan(), rand_chan(), rand_chan());
	endtask

	initial begin
		for (int i = 0; i < NUM_REFS; i++)
			ref_shadow[i] = REF_RESET[i];

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset references: hit each one exactly, then the black, white, red, green and blue corners
		for (int i = 0; i < NUM_REFS; i++)
			send_sample(ref_shadow[i][11:0], ref_shadow[i][23:12], ref_shadow[i][35:24]);
		send_sample(12'd0, 12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095, 12'd4095);
		send_sample(12'd4095, 12'd0, 12'd0);
		send_sample(12'd0, 12'd4095, 12'd0);
		send_sample(12'd0, 12'd0, 12'd4095);
		drain();

		// two references on one colour with the lower pH second, two on the rails
		write_ref(0, 64'(pack_ref(12'd1000, 12'd1000, 12'd1000, 10'd500)));
		write_ref(1, 64'(pack_ref(12'd1000, 12'd1000, 12'd1000, 10'd300)));
		write_ref(2, 64'(pack_ref(12'd3000, 12'd500, 12'd2000, 10'd1023)));
		write_ref(3, 64'(pack_ref(12'd0, 12'd0, 12'd0, 10'd0)));
		write_ref(4, 64'(pack_ref(12'd4095, 12'd4095, 12'd4095, 10'd1023)));
		write_ref(NUM_REFS, '1);                          // ignored by the block
		send_sample(12'd1000, 12'd1000, 12'd1000);        // both distances zero
		send_sample(12'd1010, 12'd1000, 12'd1000);        // tie, pH moves downward
		send_sample(12'd3000, 12'd500, 12'd2000);
		send_sample(12'd2000, 12'd500, 12'd2000);
		send_sample(12'd0, 12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095, 12'd4095);
		send_sample(12'd2048, 12'd2048, 12'd2048);
		drain();

		// all references zero: every distance ties
		for (int i = 0; i < NUM_REFS; i++)
			write_ref(i, '0);
		send_sample(12'd0, 12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095, 12'd4095);
		drain();

		// all register bits set: top colour and top pH, upper pwdata bits dropped
		for (int i = 0; i < NUM_REFS; i++)
			write_ref(i, '1);
		send_sample(12'd0, 12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095, 12'd4095);
		drain();

		// random phases, each with a fresh reference set
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			load_random_refs();
			tx_gap_pct = 24;
			rx_steady  = 1'b0;
			if (phase == 1) begin
				// result side holds off while samples keep coming, filling the pipe
				hold_requests++;
				tx_gap_pct = 0;
			end
			if (phase == 3) begin
				// long stretch with no idling on either side
				tx_gap_pct = 0;
				rx_steady  = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == 60)
					tx_gap_pct = 24;
				if (phase == 4 && n == PHASE_ITEMS / 2) begin
					// sender waits for every outstanding result
					s_tvalid <= 1'b0;
					@(negedge clk);
					while (awaited_count != 0)
						@(negedge clk);
				end
				send_random_sample();
			end
			drain();
		end

		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
